// ===== rtl/pot_average_angle_deadband_defines.svh =====
// Assertion macros shared by the RTL of the potentiometer averaging block.
// Depends on nothing; the asserting module must provide clk and rst_n.
`ifndef POT_AVERAGE_ANGLE_DEADBAND_DEFINES_SVH
`define POT_AVERAGE_ANGLE_DEADBAND_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PAD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pot_average_angle_deadband: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pot_average_angle_deadband: next-cycle check failed");

`endif

// ===== rtl/pad_pkg.sv =====
// Shared constants, register indexes and types of the potentiometer averaging block.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pad_pkg;

    // Field widths fixed by the interface
    localparam int CH_FIELD_W = 3;
    localparam int SAMPLE_W   = 12;
    localparam int ANGLE_W    = 12;
    localparam int CFG_IDX_W  = 2;

    // Default structure
    localparam int DEF_WINDOW         = 32;
    localparam int DEF_CHANNELS       = 7;
    localparam int DEF_MOTOR_CHANNELS = 6;

    // Mapping constants
    localparam int RAW_FULL  = 4095;
    localparam int SNAP_LOW  = 50;
    localparam int SNAP_HIGH = 3550;
    localparam int ANGLE_TOP = 3600;

    // Register reset values
    localparam logic [ANGLE_W-1:0] RST_RANGE_LO = 12'd0;
    localparam logic [ANGLE_W-1:0] RST_RANGE_HI = 12'd3600;
    localparam logic [ANGLE_W-1:0] RST_DEADBAND = 12'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd2;

    // Item tag carried down the pipeline
    typedef struct packed {
        logic [CH_FIELD_W-1:0] ch;
        logic                  live;  // channel in range and window already full
    } pad_tag_t;

endpackage

`default_nettype wire

// ===== rtl/pad_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read, read-first.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module pad_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/pad_window.sv =====
// Per-channel sample ring and running window sum (ring index, fill flag, sum).
// Depends on pad_pkg and pad_ram.
`timescale 1ns / 1ps
`default_nettype none

module pad_window #(
    parameter int WINDOW   = pad_pkg::DEF_WINDOW,
    parameter int CHANNELS = pad_pkg::DEF_CHANNELS
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         in_valid,
    output logic                                              in_ready,
    input  wire logic [pad_pkg::CH_FIELD_W-1:0]               channel,
    input  wire logic [pad_pkg::SAMPLE_W-1:0]                 sample,
    output logic                                              out_valid,
    input  wire logic                                         out_ready,
    output pad_pkg::pad_tag_t                                 out_tag,
    output logic [pad_pkg::SAMPLE_W+$clog2(WINDOW)-1:0]       sum
);
    import pad_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_W + IDX_W;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CX_W   = (CH_W > CH_FIELD_W) ? CH_W : CH_FIELD_W;
    localparam int ADDR_W = CH_W + IDX_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

    // Per-channel control state
    logic [IDX_W-1:0]    wr_idx_reg [CHANNELS];
    logic [CHANNELS-1:0] full_reg;
    logic [SUM_W-1:0]    sum_reg    [CHANNELS];

    // Stage 1: request accepted, old sample being read
    logic                  s1_valid_reg;
    logic [CH_FIELD_W-1:0] s1_ch_reg;
    logic [CH_W-1:0]       s1_chi_reg;
    logic                  s1_ok_reg;
    logic                  s1_full_reg;
    logic [SAMPLE_W-1:0]   s1_sample_reg;

    // Stage 2: updated sum
    logic                  s2_valid_reg;
    pad_tag_t              s2_tag_reg;
    logic [SUM_W-1:0]      s2_sum_reg;

    logic [CX_W-1:0]     chx;
    logic [CH_W-1:0]     ch_idx;
    logic                in_range;
    logic [IDX_W-1:0]    cur_idx;
    logic                cur_full;
    logic [IDX_W-1:0]    next_idx;
    logic                acc;
    logic                free1;
    logic                free2;
    logic                go1;
    logic [ADDR_W-1:0]   ram_addr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    sum_cur;
    logic [SUM_W-1:0]    sum_next;

    assign chx      = CX_W'(channel);
    assign ch_idx   = chx[CH_W-1:0];
    assign in_range = (32'(chx) < CHANNELS);
    assign cur_idx  = in_range ? wr_idx_reg[ch_idx] : '0;
    assign cur_full = in_range ? full_reg[ch_idx] : 1'b0;
    assign next_idx = (cur_idx == IDX_LAST) ? '0 : cur_idx + 1'b1;

    assign free2    = !s2_valid_reg || out_ready;
    assign go1      = s1_valid_reg && free2;
    assign free1    = !s1_valid_reg || go1;
    assign in_ready = free1;
    assign acc      = in_valid && free1;

    assign ram_addr = {ch_idx, cur_idx};

    // Read the slot being overwritten and write the new sample in the same cycle
    pad_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (2 ** ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (acc && in_range),
        .wr_addr (ram_addr),
        .wr_data (sample),
        .rd_en   (acc),
        .rd_addr (ram_addr),
        .rd_data (ram_rdata)
    );

    // Slots not yet written since reset count as zero
    assign old_sample = s1_full_reg ? ram_rdata : '0;
    assign sum_cur    = s1_ok_reg ? sum_reg[s1_chi_reg] : '0;
    assign sum_next   = sum_cur + SUM_W'(s1_sample_reg) - SUM_W'(old_sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wr_idx_reg[i] <= '0;
                sum_reg[i]    <= '0;
            end
            full_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc && in_range)
            begin
                wr_idx_reg[ch_idx] <= next_idx;
                if (cur_idx == IDX_LAST)
                begin
                    full_reg[ch_idx] <= 1'b1;
                end
            end
            if (go1 && s1_ok_reg)
            begin
                sum_reg[s1_chi_reg] <= sum_next;
            end

            if (acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (go1)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (go1)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_ch_reg     <= channel;
            s1_chi_reg    <= ch_idx;
            s1_ok_reg     <= in_range;
            s1_full_reg   <= cur_full;
            s1_sample_reg <= sample;
        end
        if (go1)
        begin
            s2_tag_reg.ch   <= s1_ch_reg;
            s2_tag_reg.live <= s1_ok_reg && s1_full_reg;
            s2_sum_reg      <= sum_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_tag   = s2_tag_reg;
    assign sum       = s2_sum_reg;

endmodule

`default_nettype wire

// ===== rtl/pad_map.sv =====
// Mean, linear mapping onto the angle range and edge snapping, four pipeline stages.
// Depends on pad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pad_map #(
    parameter int WINDOW = pad_pkg::DEF_WINDOW
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire pad_pkg::pad_tag_t                      in_tag,
    input  wire logic [pad_pkg::SAMPLE_W+$clog2(WINDOW)-1:0] sum,
    input  wire logic [pad_pkg::ANGLE_W-1:0]            span_mag,
    input  wire logic                                   span_neg,
    input  wire logic [pad_pkg::ANGLE_W-1:0]            range_lo,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output pad_pkg::pad_tag_t                           out_tag,
    output logic [pad_pkg::ANGLE_W-1:0]                 angle
);
    import pad_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_W + IDX_W;
    // floor(sum / WINDOW) as (sum * M1) >> K1, exact for every SUM_W-bit sum
    localparam int K1     = SUM_W + IDX_W;
    localparam int M1_W   = SUM_W + 1;
    localparam int MP_W   = SUM_W + M1_W;
    localparam longint unsigned M1 =
        ((64'd1 << K1) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    // floor(p / 4095) as (p * M2) >> K2, exact for every 24-bit p
    localparam int P_W    = 2 * SAMPLE_W;
    localparam int K2     = P_W + SAMPLE_W;
    localparam int M2_W   = P_W + 1;
    localparam int QP_W   = P_W + M2_W;
    localparam longint unsigned M2 =
        ((64'd1 << K2) + 64'(RAW_FULL) - 64'd1) / 64'(RAW_FULL);
    localparam int A_W    = ANGLE_W + 2;

    logic                 mean_valid_reg;
    pad_tag_t             mean_tag_reg;
    logic [SAMPLE_W-1:0]  mean_reg;

    logic                 prod_valid_reg;
    pad_tag_t             prod_tag_reg;
    logic [P_W-1:0]       prod_reg;
    logic                 prod_neg_reg;

    logic                 quot_valid_reg;
    pad_tag_t             quot_tag_reg;
    logic [SAMPLE_W-1:0]  quot_reg;
    logic                 quot_neg_reg;

    logic                 ang_valid_reg;
    pad_tag_t             ang_tag_reg;
    logic [ANGLE_W-1:0]   ang_reg;

    logic                 free0;
    logic                 free1;
    logic                 free2;
    logic                 free3;
    logic                 go0;
    logic                 go1;
    logic                 go2;
    logic                 acc;
    logic [MP_W-1:0]      mean_prod;
    logic [P_W-1:0]       prod_next;
    logic [QP_W-1:0]      quot_prod;
    logic [A_W-1:0]       base;
    logic [A_W-1:0]       qx;
    logic signed [A_W-1:0] raw_angle;
    logic [ANGLE_W-1:0]   snapped;

    assign free3    = !ang_valid_reg || out_ready;
    assign go2      = quot_valid_reg && free3;
    assign free2    = !quot_valid_reg || go2;
    assign go1      = prod_valid_reg && free2;
    assign free1    = !prod_valid_reg || go1;
    assign go0      = mean_valid_reg && free1;
    assign free0    = !mean_valid_reg || go0;
    assign in_ready = free0;
    assign acc      = in_valid && free0;

    assign mean_prod = MP_W'(sum) * MP_W'(M1);
    assign prod_next = P_W'(mean_reg) * P_W'(span_mag);
    assign quot_prod = QP_W'(prod_reg) * QP_W'(M2);

    // Magnitude truncates, sign applied afterwards: truncation toward zero
    assign base      = A_W'(range_lo);
    assign qx        = A_W'(quot_reg);
    assign raw_angle = quot_neg_reg ? $signed(base - qx) : $signed(base + qx);

    always_comb
    begin
        if (raw_angle < SNAP_LOW)
        begin
            snapped = '0;
        end
        else if (raw_angle > SNAP_HIGH)
        begin
            snapped = ANGLE_W'(ANGLE_TOP);
        end
        else
        begin
            snapped = raw_angle[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            quot_valid_reg <= 1'b0;
            ang_valid_reg  <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                mean_valid_reg <= 1'b1;
            end
            else if (go0)
            begin
                mean_valid_reg <= 1'b0;
            end

            if (go0)
            begin
                prod_valid_reg <= 1'b1;
            end
            else if (go1)
            begin
                prod_valid_reg <= 1'b0;
            end

            if (go1)
            begin
                quot_valid_reg <= 1'b1;
            end
            else if (go2)
            begin
                quot_valid_reg <= 1'b0;
            end

            if (go2)
            begin
                ang_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ang_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            mean_tag_reg <= in_tag;
            mean_reg     <= mean_prod[K1 +: SAMPLE_W];
        end
        if (go0)
        begin
            prod_tag_reg <= mean_tag_reg;
            prod_reg     <= prod_next;
            prod_neg_reg <= span_neg;
        end
        if (go1)
        begin
            quot_tag_reg <= prod_tag_reg;
            quot_reg     <= quot_prod[K2 +: SAMPLE_W];
            quot_neg_reg <= prod_neg_reg;
        end
        if (go2)
        begin
            ang_tag_reg <= quot_tag_reg;
            ang_reg     <= snapped;
        end
    end

    assign out_valid = ang_valid_reg;
    assign out_tag   = ang_tag_reg;
    assign angle     = ang_reg;

endmodule

`default_nettype wire

// ===== rtl/pad_deadband.sv =====
// Motor target deadband with last-sent memory, and the result register.
// Depends on pad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pad_deadband #(
    parameter int MOTOR_CHANNELS = pad_pkg::DEF_MOTOR_CHANNELS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire pad_pkg::pad_tag_t              in_tag,
    input  wire logic [pad_pkg::ANGLE_W-1:0]    in_angle,
    input  wire logic [pad_pkg::ANGLE_W-1:0]    deadband,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [pad_pkg::CH_FIELD_W-1:0]      out_channel,
    output logic [pad_pkg::ANGLE_W-1:0]         angle,
    output logic                                angle_valid,
    output logic                                move
);
    import pad_pkg::*;

    localparam int MC_W = (MOTOR_CHANNELS > 1) ? $clog2(MOTOR_CHANNELS) : 1;
    localparam int MX_W = (MC_W > CH_FIELD_W) ? MC_W : CH_FIELD_W;

    logic [ANGLE_W-1:0]    last_reg [MOTOR_CHANNELS];

    logic                  out_valid_reg;
    logic [CH_FIELD_W-1:0] out_channel_reg;
    logic [ANGLE_W-1:0]    angle_reg;
    logic                  angle_valid_reg;
    logic                  move_reg;

    logic [MX_W-1:0]       chx;
    logic [MC_W-1:0]       m_idx;
    logic                  motor;
    logic [ANGLE_W-1:0]    last_cur;
    logic [ANGLE_W-1:0]    diff;
    logic                  hit;
    logic                  acc;

    assign chx      = MX_W'(in_tag.ch);
    assign m_idx    = chx[MC_W-1:0];
    assign motor    = in_tag.live && (32'(chx) < MOTOR_CHANNELS);
    assign last_cur = motor ? last_reg[m_idx] : '0;
    assign diff     = (in_angle >= last_cur) ? in_angle - last_cur : last_cur - in_angle;
    assign hit      = motor && (diff >= deadband);

    assign in_ready = !out_valid_reg || out_ready;
    assign acc      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTOR_CHANNELS; i++)
            begin
                last_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc && hit)
            begin
                last_reg[m_idx] <= in_angle;
            end
            if (acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            out_channel_reg <= in_tag.ch;
            angle_reg       <= in_tag.live ? in_angle : '0;
            angle_valid_reg <= in_tag.live;
            move_reg        <= hit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign angle       = angle_reg;
    assign angle_valid = angle_valid_reg;
    assign move        = move_reg;

endmodule

`default_nettype wire

// ===== rtl/pot_average_angle_deadband.sv =====
// Top level of the potentiometer averaging block: configuration registers and pipeline.
// Depends on pad_pkg, pad_window, pad_map, pad_deadband and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "pot_average_angle_deadband_defines.svh"

// Per-channel moving average of raw potentiometer samples over a ring of WINDOW
// entries, mapped linearly from 0..4095 onto the range register pair low..high
// (integer, truncating toward zero), snapped to 0 below 50 and to 3600 above 3550.
// Every accepted request gives exactly one result, in order. A channel's first
// WINDOW samples only fill its ring and report angle_valid low; channels at or above
// CHANNELS change nothing and report zeros. On motor channels a result raises
// move when it differs from the last value that raised move by at least the
// deadband. Throughput is one request per clock while results are taken: the
// sample memory takes one write and one read for each request and the window sum
// is kept as a running sum, so nothing iterates. The edge that takes a request
// reads the ring and loads the request register; the sum update, mean, product,
// division by 4095, offset and snap, and the deadband with the result register
// then each have a register of their own, in that order. Results wait in the
// result register while new requests keep flowing into the pipeline until it is full.
// No clearing pass is needed after reset: until a ring has wrapped the slot it
// overwrites is taken as zero. Write the configuration registers only while the
// block is idle.
module pot_average_angle_deadband #(
    parameter int WINDOW         = pad_pkg::DEF_WINDOW,
    parameter int CHANNELS       = pad_pkg::DEF_CHANNELS,
    parameter int MOTOR_CHANNELS = pad_pkg::DEF_MOTOR_CHANNELS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Sample requests
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [pad_pkg::CH_FIELD_W-1:0] channel,
    input  wire logic [pad_pkg::SAMPLE_W-1:0]   sample,
    // Results
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [pad_pkg::CH_FIELD_W-1:0]      out_channel,
    output logic [pad_pkg::ANGLE_W-1:0]         angle,
    output logic                                angle_valid,
    output logic                                move,
    // Configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pad_pkg::ANGLE_W-1:0]    cfg_data
);
    import pad_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

    // Configuration registers
    logic [ANGLE_W-1:0] range_lo_reg;
    logic [ANGLE_W-1:0] range_hi_reg;
    logic [ANGLE_W-1:0] deadband_reg;

    // Span of the mapping, held as sign and magnitude
    logic [ANGLE_W-1:0] span_mag_reg;
    logic [ANGLE_W-1:0] span_mag_next;
    logic               span_neg_reg;
    logic               span_neg_next;

    // Pipeline links
    logic               win_valid;
    logic               win_ready;
    pad_tag_t           win_tag;
    logic [SUM_W-1:0]   win_sum;
    logic               map_valid;
    logic               map_ready;
    pad_tag_t           map_tag;
    logic [ANGLE_W-1:0] map_angle;

    // Writes are always taken at once
    assign cfg_ready = 1'b1;

    assign span_neg_next = range_hi_reg < range_lo_reg;
    assign span_mag_next = span_neg_next ? range_lo_reg - range_hi_reg
                                         : range_hi_reg - range_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_lo_reg <= RST_RANGE_LO;
            range_hi_reg <= RST_RANGE_HI;
            deadband_reg <= RST_DEADBAND;
            span_mag_reg <= RST_RANGE_HI - RST_RANGE_LO;
            span_neg_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_RANGE_LO: range_lo_reg <= cfg_data;
                    REG_RANGE_HI: range_hi_reg <= cfg_data;
                    REG_DEADBAND: deadband_reg <= cfg_data;
                    default:      ;  // unmapped index: drop the write
                endcase
            end
            // Follow the range registers; settled long before a request reaches the product
            span_mag_reg <= span_mag_next;
            span_neg_reg <= span_neg_next;
        end
    end

    // Ring memory and running sum
    pad_window #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .channel   (channel),
        .sample    (sample),
        .out_valid (win_valid),
        .out_ready (win_ready),
        .out_tag   (win_tag),
        .sum       (win_sum)
    );

    // Mean, mapping and snap
    pad_map #(
        .WINDOW (WINDOW)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .in_tag    (win_tag),
        .sum       (win_sum),
        .span_mag  (span_mag_reg),
        .span_neg  (span_neg_reg),
        .range_lo  (range_lo_reg),
        .out_valid (map_valid),
        .out_ready (map_ready),
        .out_tag   (map_tag),
        .angle     (map_angle)
    );

    // Deadband on motor targets and the result register
    pad_deadband #(
        .MOTOR_CHANNELS (MOTOR_CHANNELS)
    ) u_deadband (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (map_valid),
        .in_ready    (map_ready),
        .in_tag      (map_tag),
        .in_angle    (map_angle),
        .deadband    (deadband_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .angle       (angle),
        .angle_valid (angle_valid),
        .move        (move)
    );

    // A result without a valid angle carries no angle and no move
    `PAD_ASSERT_SAME(a_idle_result_zero, out_valid && !angle_valid, angle == '0 && !move)
    // Only motor channels raise move
    `PAD_ASSERT_SAME(a_move_on_motor, out_valid && move, 32'(out_channel) < MOTOR_CHANNELS)
    // Snapped angles never land between zero and the low snap point, nor above the top
    `PAD_ASSERT_SAME(a_angle_snapped, out_valid && angle_valid,
        angle <= ANGLE_W'(ANGLE_TOP) && (angle == '0 || angle >= ANGLE_W'(SNAP_LOW)))

endmodule

`default_nettype wire

// ===== verif/pot_average_angle_deadband_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for pot_average_angle_deadband: a directed table, then random phases
// under several register settings, each result checked against the predictor kept here or a pinned table row.
// Depends on pad_pkg and the RTL of the block.
module pot_average_angle_deadband_tb;
    import pad_pkg::*;

    localparam int WIN          = DEF_WINDOW;
    localparam int N_CH         = DEF_CHANNELS;
    localparam int N_MOTOR      = DEF_MOTOR_CHANNELS;
    localparam int PIPE_LATENCY = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 130;
    localparam int HOLD_CYCLES  = 300;
    localparam int DIR_ROWS     = 12;
    localparam int PRINT_CAP    = 100;
    localparam int MAX_GAP      = 5;
    localparam int RAW_TOP      = (1 << SAMPLE_W) - 1;
    // Index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [CH_FIELD_W-1:0] ch;
        logic [ANGLE_W-1:0]    angle;
        logic                  valid;
        logic                  move;
    } angle_result_t;

    typedef struct {
        logic [CH_FIELD_W-1:0] ch;
        logic [SAMPLE_W-1:0]   smp;
        int                    reps;
        bit                    pinned;
        angle_result_t         want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [CH_FIELD_W-1:0] channel     = '0;
    logic [SAMPLE_W-1:0]   sample      = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [CH_FIELD_W-1:0] out_channel;
    logic [ANGLE_W-1:0]    angle;
    logic                  angle_valid;
    logic                  move;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [ANGLE_W-1:0]    cfg_data    = '0;

    pot_average_angle_deadband u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .angle       (angle),
        .angle_valid (angle_valid),
        .move        (move),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Period 20 ns
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Predictor state: its own copy of the rings, indexes, targets and registers
    logic [SAMPLE_W-1:0] ring_mem [N_CH][WIN];
    int                  ring_pos [N_CH];
    bit                  ring_full [N_CH];
    int                  motor_target [N_MOTOR];
    int                  motor_sent [N_MOTOR];
    logic [ANGLE_W-1:0]  pos_min   = RST_RANGE_LO;
    logic [ANGLE_W-1:0]  pos_max   = RST_RANGE_HI;
    logic [ANGLE_W-1:0]  dead_band = RST_DEADBAND;

    angle_result_t pending_angles [$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Shared between the request side and the result side
    bit tx_calm      = 1'b0;   // no gaps between requests
    bit rx_calm      = 1'b0;   // no stalls between results
    int rx_hold_ask  = 0;      // long hold-off asked of the result side
    int rx_hold_left = 0;
    int rx_wait      = 0;

    // Store the sample, advance the ring, and work out the one result it causes
    function automatic angle_result_t track_sample(input logic [CH_FIELD_W-1:0] ch,
                                                   input logic [SAMPLE_W-1:0] smp);
        angle_result_t r;
        int unsigned   total;
        int            mean;
        int            span;
        int            a;
        int            diff;
        int            j;
        r = '{ch, '0, 1'b0, 1'b0};
        if (ch < N_CH) begin
            ring_mem[ch][ring_pos[ch]] = smp;
            ring_pos[ch] = (ring_pos[ch] + 1) % WIN;
            if (!ring_full[ch]) begin
                // the sample that closes the first wrap still gives no angle
                if (ring_pos[ch] == 0)
                    ring_full[ch] = 1'b1;
            end
            else begin
                total = 0;
                for (j = 0; j < WIN; j++)
                    total += ring_mem[ch][j];
                mean = int'(total / WIN);
                span = int'(pos_max) - int'(pos_min);
                // signed product, quotient truncates toward zero
                a = mean * span / RAW_FULL + int'(pos_min);
                if (a < SNAP_LOW)
                    a = 0;
                if (a > SNAP_HIGH)
                    a = ANGLE_TOP;
                r.angle = a[ANGLE_W-1:0];
                r.valid = 1'b1;
                if (ch < N_MOTOR) begin
                    motor_target[ch] = a;
                    diff = (a >= motor_sent[ch]) ? a - motor_sent[ch] : motor_sent[ch] - a;
                    if (diff >= int'(dead_band)) begin
                        motor_sent[ch] = a;
                        r.move = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    endtask

    // Offer one request after a drawn gap; hold it until taken, then queue its result.
    // A pinned row queues the typed-in result but still runs the predictor for its state.
    task automatic offer_sample(input logic [CH_FIELD_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                                input bit pinned, input angle_result_t want);
        int            gap;
        angle_result_t predicted;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= smp;
        do @(posedge clk); while (!in_ready);
        predicted = track_sample(ch, smp);
        pending_angles.push_back(pinned ? want : predicted);
    endtask

    // Drop the request valid and wait until every queued result has come back
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_angles.size() != 0)
            @(posedge clk);
    endtask

    // Hold one register write until taken; the caller drops cfg_valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_RANGE_LO: pos_min   = val;
            REG_RANGE_HI: pos_max   = val;
            REG_DEADBAND: dead_band = val;
            default: ;
        endcase
    endtask

    // Result side: check every taken result, then draw the stall before the next one.
    // A long hold-off asked by the request side is counted out here, cycle by cycle.
    always @(posedge clk)
    begin : result_side
        angle_result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (pending_angles.size() == 0) begin
                    report_mismatch("result with nothing pending, out_channel", out_channel, -1);
                end
                else begin
                    want = pending_angles.pop_front();
                    if (out_channel !== want.ch)
                        report_mismatch("out_channel", out_channel, want.ch);
                    if (angle !== want.angle)
                        report_mismatch("angle", angle, want.angle);
                    if (angle_valid !== want.valid)
                        report_mismatch("angle_valid", angle_valid, want.valid);
                    if (move !== want.move)
                        report_mismatch("move", move, want.move);
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (rx_hold_ask > 0) begin
                rx_hold_left = rx_hold_ask;
                rx_hold_ask  = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0) begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it takes far longer than the slowest correct one
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        dir_row_t              dir_rows [DIR_ROWS];
        int                    r;
        int                    k;
        int                    phase;
        int                    roll;
        int                    v;
        int                    level [N_CH];
        logic [CH_FIELD_W-1:0] ch;
        logic [SAMPLE_W-1:0]   smp;
        logic [ANGLE_W-1:0]    set_min;
        logic [ANGLE_W-1:0]    set_max;
        logic [ANGLE_W-1:0]    set_db;

        for (r = 0; r < N_CH; r++) begin
            ring_pos[r]  = 0;
            ring_full[r] = 1'b0;
            for (k = 0; k < WIN; k++)
                ring_mem[r][k] = '0;
        end
        for (r = 0; r < N_MOTOR; r++) begin
            motor_target[r] = 0;
            motor_sent[r]   = 0;
        end

        // Directed table, reset register values (range 0..3600, deadband 6)
        // out of range channel: nothing stored, zeros back
        dir_rows[0]  = '{3'd7, 12'd4095, 1,  1'b1, '{3'd7, 12'd0,    1'b0, 1'b0}};
        dir_rows[1]  = '{3'd7, 12'd0,    1,  1'b1, '{3'd7, 12'd0,    1'b0, 1'b0}};
        // fill channel 0 at full scale; the wrap itself gives no angle
        dir_rows[2]  = '{3'd0, 12'd4095, 32, 1'b1, '{3'd0, 12'd0,    1'b0, 1'b0}};
        // first angle: top of range, far past the deadband from zero
        dir_rows[3]  = '{3'd0, 12'd4095, 1,  1'b1, '{3'd0, 12'd3600, 1'b1, 1'b1}};
        dir_rows[4]  = '{3'd0, 12'd4095, 1,  1'b1, '{3'd0, 12'd3600, 1'b1, 1'b0}};
        // fill channel 1 at zero; angle 0 equals last sent, so no move
        dir_rows[5]  = '{3'd1, 12'd0,    32, 1'b1, '{3'd1, 12'd0,    1'b0, 1'b0}};
        dir_rows[6]  = '{3'd1, 12'd0,    1,  1'b1, '{3'd1, 12'd0,    1'b1, 1'b0}};
        // non-motor channel reports the angle and never moves
        dir_rows[7]  = '{3'd6, 12'd4095, 32, 1'b1, '{3'd6, 12'd0,    1'b0, 1'b0}};
        dir_rows[8]  = '{3'd6, 12'd4095, 1,  1'b1, '{3'd6, 12'd3600, 1'b1, 1'b0}};
        // step away from the extremes: left to the predictor; then one more out of range request
        dir_rows[9]  = '{3'd0, 12'd0,    3,  1'b0, '0};
        dir_rows[10] = '{3'd1, 12'd4095, 2,  1'b0, '0};
        dir_rows[11] = '{3'd7, 12'd2730, 1,  1'b1, '{3'd7, 12'd0,    1'b0, 1'b0}};

        // Hold reset, once, then release it
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_ROWS; r++)
            for (k = 0; k < dir_rows[r].reps; k++)
                offer_sample(dir_rows[r].ch, dir_rows[r].smp, dir_rows[r].pinned, dir_rows[r].want);

        for (r = 0; r < N_CH; r++)
            level[r] = $urandom_range(0, RAW_TOP);

        for (phase = 0; phase < PHASES; phase++) begin
            // registers change only with the block drained
            settle_block();
            case (phase)
                0: begin set_min = 12'd0;    set_max = 12'd3600; set_db = 12'd0;    end // zero deadband
                1: begin set_min = 12'd3600; set_max = 12'd0;    set_db = 12'd6;    end // reversed
                2: begin set_min = 12'd0;    set_max = 12'd4095; set_db = 12'd3600; end // range past 3600
                3: begin set_min = 12'd4095; set_max = 12'd4095; set_db = 12'd1;    end
                4: begin set_min = 12'd0;    set_max = 12'd0;    set_db = 12'd4095; end
                5: begin set_min = 12'd100;  set_max = 12'd3500; set_db = 12'd25;   end
                6: begin set_min = RST_RANGE_LO; set_max = RST_RANGE_HI;
                         set_db = RST_DEADBAND; end
                default: begin
                    set_min = ANGLE_W'($urandom_range(0, ANGLE_TOP));
                    set_max = ANGLE_W'($urandom_range(0, ANGLE_TOP));
                    set_db  = ANGLE_W'($urandom_range(0, 60));
                end
            endcase
            write_reg(REG_RANGE_LO, set_min);
            write_reg(REG_RANGE_HI, set_max);
            write_reg(REG_DEADBAND, set_db);
            if (phase == 3)
                write_reg(REG_SPARE, ANGLE_W'($urandom_range(0, RAW_TOP)));
            cfg_valid <= 1'b0;

            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // stall the result side for a long stretch while requests keep coming,
                // so the pipeline fills and pushes back on its input
                tx_calm     = 1'b1;
                rx_hold_ask = HOLD_CYCLES;
            end

            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 5 && k == PHASE_ITEMS / 2)
                    settle_block();
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    ch  = '1;
                    smp = SAMPLE_W'($urandom_range(0, RAW_TOP));
                end
                else begin
                    ch   = CH_FIELD_W'($urandom_range(0, N_CH - 1));
                    roll = $urandom_range(0, 99);
                    if (roll < 8) begin
                        smp = SAMPLE_W'($urandom_range(0, RAW_TOP));
                    end
                    else if (roll < 12) begin
                        smp = ($urandom_range(0, 1) == 1) ? 12'd4095 : 12'd0;
                    end
                    else begin
                        // slow drift per channel keeps the mean near the deadband edge;
                        // an occasional jump reaches the snap zones
                        if ($urandom_range(0, 49) == 0)
                            level[ch] = $urandom_range(0, RAW_TOP);
                        else
                            level[ch] = level[ch] + int'($urandom_range(0, 40)) - 20;
                        if (level[ch] < 0)
                            level[ch] = 0;
                        if (level[ch] > RAW_TOP)
                            level[ch] = RAW_TOP;
                        v = level[ch] + int'($urandom_range(0, 16)) - 8;
                        if (v < 0)
                            v = 0;
                        if (v > RAW_TOP)
                            v = RAW_TOP;
                        smp = v[SAMPLE_W-1:0];
                    end
                end
                offer_sample(ch, smp, 1'b0, '0);
            end
        end

        // Drain, then let the pipeline run out in case anything stray follows
        settle_block();
        repeat (3 * PIPE_LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pad_pkg.sv
rtl/pad_ram.sv
rtl/pad_window.sv
rtl/pad_map.sv
rtl/pad_deadband.sv
rtl/pot_average_angle_deadband.sv
verif/pot_average_angle_deadband_tb.sv
